// ----- hw/rtl/otb_pkg.sv -----
// Shared types and codes for the one-shot timer bank.
`default_nettype none

package otb_pkg;

    localparam int MAX_RESULTS = 8;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] KIND_STARTED = 2'd0;
    localparam logic [1:0] KIND_NO_FREE = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] slot;
        logic       last;
    } res_t;

    typedef struct packed {
        logic push;
        res_t res;
    } out_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/one_shot_timer_bank.sv -----
// Top level of the one-shot timer bank: stream ports and result output register.
`default_nettype none

// A bank of NUM_TIMERS one-shot countdown timers, all idle after reset. The
// input word carries a command (start, stop, tick). Start takes the lowest idle
// timer and returns its number (or a no-free status); stop clears a timer and
// returns nothing; tick counts every running timer down once and returns one
// word per expiry in ascending timer order, tlast on the final one. The block
// takes one command at a time. A start scans the timers from the lowest
// upward to the first idle one (at most NUM_TIMERS are scanned). A tick reads
// one counter per cycle from the count memory and decrements it in the single
// shared unit, but a full result register downstream stalls the scan. At most 8
// expiries are reported per tick; further expiring timers still go idle.
module one_shot_timer_bank #(
    parameter int NUM_TIMERS  = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // interval[15:0], timer_id[18:16]
    input  wire logic [1:0]  s_axis_tuser,  // command[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,  // slot[2:0]
    output logic      [1:0]  m_axis_tuser,  // kind[1:0]
    output logic             m_axis_tlast
);

    import otb_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    out_req_t               out_req;
    logic                   can_load;
    logic                   m_valid_reg, m_valid_next;
    res_t                   res_reg, res_next;

    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [COUNT_WIDTH-1:0] rd_data;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;

    otb_seq #(
        .NUM_TIMERS  (NUM_TIMERS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .command  (s_axis_tuser),
        .interval (s_axis_tdata[15:0]),
        .timer_id (s_axis_tdata[18:16]),
        .can_load (can_load),
        .out_req  (out_req),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    otb_mem #(
        .DEPTH (NUM_TIMERS),
        .WIDTH (COUNT_WIDTH),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign can_load = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        if (out_req.push)
        begin
            m_valid_next = 1'b1;
            res_next     = out_req.res;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            res_reg     <= '0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            res_reg     <= res_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, res_reg.slot};
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = res_reg.last;

endmodule

`default_nettype wire

// ----- hw/rtl/otb_mem.sv -----
// Count memory: one write port, one registered read port.
`default_nettype none

module otb_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16,
    parameter int AW    = 3
) (
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/otb_seq.sv -----
// Sequencer: busy bits, timer scan, shared decrement unit and result ordering.
`default_nettype none

module otb_seq #(
    parameter int NUM_TIMERS  = 8,
    parameter int COUNT_WIDTH = 16,
    parameter int IDX_W       = 3,
    parameter int CNT_W       = 4
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             command,
    input  wire logic [15:0]            interval,
    input  wire logic [2:0]             timer_id,
    input  wire logic                   can_load,
    output otb_pkg::out_req_t           out_req,
    output logic                        rd_en,
    output logic      [IDX_W-1:0]       rd_addr,
    input  wire logic [COUNT_WIDTH-1:0] rd_data,
    output logic                        wr_en,
    output logic      [IDX_W-1:0]       wr_addr,
    output logic      [COUNT_WIDTH-1:0] wr_data
);

    import otb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_TICK  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NUM_TIMERS);
    localparam logic [31:0] COUNT_MASK = 32'((64'(1) << COUNT_WIDTH) - 64'(1));

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         scan_reg, scan_next;
    logic [NUM_TIMERS-1:0]    busy_reg, busy_next;
    logic [COUNT_WIDTH-1:0]   ivl_reg, ivl_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    logic [RES_CNT_W-1:0]     n_reg, n_next;
    logic                     held_vld_reg, held_vld_next;
    logic [2:0]               held_slot_reg, held_slot_next;

    logic [IDX_W-1:0]         scan_idx;
    logic [IDX_W+2:0]         scan_ext;
    logic [IDX_W+2:0]         rd_idx_ext;
    logic [IDX_W+2:0]         tid_ext;
    logic                     tid_ok;
    logic [31:0]              ivl_wide;
    logic [31:0]              ivl_sat;
    logic [COUNT_WIDTH-1:0]   dec;
    logic                     report;
    logic                     stall;

    assign scan_idx   = scan_reg[IDX_W-1:0];
    assign scan_ext   = (IDX_W + 3)'(scan_idx);
    assign rd_idx_ext = (IDX_W + 3)'(rd_idx_reg);
    assign tid_ext    = (IDX_W + 3)'(timer_id);
    assign tid_ok     = 32'(timer_id) < 32'(NUM_TIMERS);

    assign ivl_wide = 32'(interval);

    always_comb
    begin
        ivl_sat = (ivl_wide > COUNT_MASK) ? COUNT_MASK : ivl_wide;
        if (ivl_sat == 32'd0)
        begin
            ivl_sat = 32'd1;
        end
    end

    assign dec    = rd_data - COUNT_WIDTH'(1);
    assign report = rd_vld_reg && busy_reg[rd_idx_reg] && (dec == '0)
                    && (n_reg < RES_CNT_W'(MAX_RESULTS));
    assign stall  = report && held_vld_reg && !can_load;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        busy_next      = busy_reg;
        ivl_next       = ivl_reg;
        rd_vld_next    = rd_vld_reg;
        rd_idx_next    = rd_idx_reg;
        n_next         = n_reg;
        held_vld_next  = held_vld_reg;
        held_slot_next = held_slot_reg;
        rd_en          = 1'b0;
        rd_addr        = scan_idx;
        wr_en          = 1'b0;
        wr_addr        = scan_idx;
        wr_data        = ivl_reg;
        out_req        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    case (command)
                        CMD_START:
                        begin
                            ivl_next   = COUNT_WIDTH'(ivl_sat);
                            scan_next  = '0;
                            state_next = ST_START;
                        end
                        CMD_STOP:
                        begin
                            if (tid_ok)
                            begin
                                busy_next[tid_ext[IDX_W-1:0]] = 1'b0;
                            end
                        end
                        CMD_TICK:
                        begin
                            scan_next     = '0;
                            rd_vld_next   = 1'b0;
                            n_next        = '0;
                            held_vld_next = 1'b0;
                            state_next    = ST_TICK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_START:
            begin
                if (scan_reg == SCAN_END)
                begin
                    if (can_load)
                    begin
                        out_req.push     = 1'b1;
                        out_req.res.kind = KIND_NO_FREE;
                        out_req.res.slot = 3'd0;
                        out_req.res.last = 1'b1;
                        state_next       = ST_IDLE;
                    end
                end
                else if (!busy_reg[scan_idx])
                begin
                    if (can_load)
                    begin
                        wr_en               = 1'b1;
                        busy_next[scan_idx] = 1'b1;
                        out_req.push        = 1'b1;
                        out_req.res.kind    = KIND_STARTED;
                        out_req.res.slot    = scan_ext[2:0];
                        out_req.res.last    = 1'b1;
                        state_next          = ST_IDLE;
                    end
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            ST_TICK:
            begin
                if (!stall)
                begin
                    if (rd_vld_reg && busy_reg[rd_idx_reg])
                    begin
                        wr_en   = 1'b1;
                        wr_addr = rd_idx_reg;
                        wr_data = dec;
                        if (dec == '0)
                        begin
                            busy_next[rd_idx_reg] = 1'b0;
                        end
                    end
                    if (report)
                    begin
                        if (held_vld_reg)
                        begin
                            out_req.push     = 1'b1;
                            out_req.res.kind = KIND_EXPIRED;
                            out_req.res.slot = held_slot_reg;
                            out_req.res.last = 1'b0;
                        end
                        held_vld_next  = 1'b1;
                        held_slot_next = rd_idx_ext[2:0];
                        n_next         = n_reg + RES_CNT_W'(1);
                    end
                    if (scan_reg != SCAN_END)
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = scan_idx;
                        rd_idx_next = scan_idx;
                        rd_vld_next = 1'b1;
                        scan_next   = scan_reg + CNT_W'(1);
                    end
                    else
                    begin
                        rd_vld_next = 1'b0;
                        if (!rd_vld_reg)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!held_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (can_load)
                begin
                    out_req.push     = 1'b1;
                    out_req.res.kind = KIND_EXPIRED;
                    out_req.res.slot = held_slot_reg;
                    out_req.res.last = 1'b1;
                    held_vld_next    = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            busy_reg      <= '0;
            ivl_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            n_reg         <= '0;
            held_vld_reg  <= 1'b0;
            held_slot_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            busy_reg      <= busy_next;
            ivl_reg       <= ivl_next;
            rd_vld_reg    <= rd_vld_next;
            rd_idx_reg    <= rd_idx_next;
            n_reg         <= n_next;
            held_vld_reg  <= held_vld_next;
            held_slot_reg <= held_slot_next;
        end
    end

endmodule

`default_nettype wire
